// ----- hdl/critical_path_analysis_top_macros.svh -----
// Assertion macros shared by the critical path analysis RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef CRITICAL_PATH_ANALYSIS_TOP_MACROS_SVH
`define CRITICAL_PATH_ANALYSIS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CPA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/cpa_pkg.sv -----
// Package for the critical path analysis block: sizes and the stored edge word.
// Depends on nothing.
`default_nettype none
package cpa_pkg;
   localparam int MAX_VERTICES = 32;
   localparam int MAX_EDGES    = 64;
   localparam int VTX_W        = 5;
   localparam int VCNT_W       = 6;
   localparam int EIDX_W       = 6;
   localparam int ECNT_W       = 7;
   localparam int DUR_W        = 16;
   localparam int ET_W         = 22;
   localparam int LT_W         = 23;
   localparam int LS_W         = 24;
   localparam int DEG_W        = 7;

   typedef struct packed {
      logic [DUR_W-1:0] duration;
      logic [VTX_W-1:0] target;
      logic [VTX_W-1:0] source;
   } edge_word_type;

   localparam int EDGE_W = $bits(edge_word_type);
endpackage
`default_nettype wire

// ----- hdl/cpa_edge_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. Depends on nothing.
`default_nettype none
module cpa_edge_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 26
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hdl/critical_path_analysis_top.sv -----
// Critical path analysis top level: edge loading, topological sort, slack and report.
// Depends on cpa_pkg, cpa_edge_ram and critical_path_analysis_top_macros.svh.
//
// Usage. Edges are presented on the req_ ports and taken at a clock edge where
// start is high and busy is low; in the load phase one edge beat is taken every
// cycle. Edges beyond 64 are dropped. The beat with req_last_edge set ends the
// load: busy rises and the block counts in-degrees, runs a stack-based
// topological sort that also finds the earliest event times, then lowers the
// latest times in reverse order and reports every edge whose endpoints lie
// below the vertex count. A run makes up to 3n + 1 walks of the edge RAM for n
// vertices, each reading one stored edge per cycle, and the block takes no new
// edges until busy falls. Results come as single-cycle rsp_valid beats; the
// receiver cannot stall them. A cyclic graph gives one beat with rsp_status
// set. The final beat carries rsp_last_result. After a run the edge store is
// emptied and busy falls. The vertex count register is written through
// csr_valid/csr_ready (always ready); the user is to write it only while the
// block is idle, which the block itself does not enforce. Reset empties the
// store and sets the vertex count to one.
`default_nettype none
module critical_path_analysis_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [cpa_pkg::VTX_W-1:0]   req_edge_source,
   input  wire logic [cpa_pkg::VTX_W-1:0]   req_edge_target,
   input  wire logic [cpa_pkg::DUR_W-1:0]   req_edge_duration,
   input  wire logic                        req_last_edge,
   output logic                             rsp_valid,
   output logic                             rsp_status,
   output logic [cpa_pkg::VTX_W-1:0]        rsp_out_source,
   output logic [cpa_pkg::VTX_W-1:0]        rsp_out_target,
   output logic [cpa_pkg::DUR_W-1:0]        rsp_out_duration,
   output logic [cpa_pkg::ET_W-1:0]         rsp_earliest_start,
   output logic signed [cpa_pkg::LS_W-1:0]  rsp_latest_start,
   output logic                             rsp_is_critical,
   output logic                             rsp_last_result,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [cpa_pkg::VCNT_W-1:0]  csr_vertex_count
);
   import cpa_pkg::*;
`include "critical_path_analysis_top_macros.svh"

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_DEG   = 4'd2;
   localparam logic [3:0] S_PUSH  = 4'd3;
   localparam logic [3:0] S_POP   = 4'd4;
   localparam logic [3:0] S_RELAX = 4'd5;
   localparam logic [3:0] S_LINIT = 4'd6;
   localparam logic [3:0] S_BHEAD = 4'd7;
   localparam logic [3:0] S_BSCAN = 4'd8;
   localparam logic [3:0] S_EHEAD = 4'd9;
   localparam logic [3:0] S_ESCAN = 4'd10;
   localparam logic [3:0] S_CYC   = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   localparam logic [ECNT_W-1:0] EDGE_LIMIT = ECNT_W'(MAX_EDGES);
   localparam logic [VCNT_W-1:0] VTX_LIMIT  = VCNT_W'(MAX_VERTICES);

   // Control registers.
   logic [3:0]         state_ff, state_in;
   logic [VCNT_W-1:0]  cfg_ff, cfg_in;
   logic [ECNT_W-1:0]  ecnt_ff, ecnt_in;
   logic [VCNT_W-1:0]  n_ff, n_in;
   logic [ECNT_W-1:0]  addr_ff, addr_in;
   logic               pv_ff, pv_in;
   logic [VCNT_W-1:0]  sp_ff, sp_in;
   logic [VCNT_W-1:0]  ord_ff, ord_in;
   logic [VCNT_W-1:0]  vi_ff, vi_in;
   logic [ECNT_W-1:0]  act_ff, act_in;
   logic [ECNT_W-1:0]  emit_ff, emit_in;
   logic [VTX_W-1:0]   j_ff, j_in;
   logic [ET_W-1:0]    ej_ff, ej_in;
   logic signed [LT_W-1:0] acc_ff, acc_in;

   // Vertex tables, each read at one muxed address per cycle.
   logic [DEG_W-1:0]        indeg_ff [MAX_VERTICES];
   logic [ET_W-1:0]         earl_ff  [MAX_VERTICES];
   logic signed [LT_W-1:0]  lat_ff   [MAX_VERTICES];
   logic [VTX_W-1:0]        stack_ff [MAX_VERTICES];
   logic [VTX_W-1:0]        topo_ff  [MAX_VERTICES];

   // Registered result beat.
   logic                    rv_ff, rv_in;
   logic                    rst_ff, rst_in;
   logic [VTX_W-1:0]        rsrc_ff, rsrc_in, rtgt_ff, rtgt_in;
   logic [DUR_W-1:0]        rdur_ff, rdur_in;
   logic [ET_W-1:0]         res_ff, res_in;
   logic signed [LS_W-1:0]  rls_ff, rls_in;
   logic                    rcrit_ff, rcrit_in, rlast_ff, rlast_in;

   // Edge RAM ports.
   logic                 ram_we;
   logic [EDGE_W-1:0]    ram_rdata;
   edge_word_type        wr_edge, ed;

   // Table write controls.
   logic               deg_we, earl_we, lat_we, stack_we, topo_we;
   logic [VTX_W-1:0]   deg_wa, earl_wa, lat_wa, stack_wa, topo_wa;
   logic [DEG_W-1:0]   deg_wd;
   logic [ET_W-1:0]    earl_wd;
   logic signed [LT_W-1:0] lat_wd;
   logic [VTX_W-1:0]   stack_wd, topo_wd;

   // Table read addresses and data.
   logic [VTX_W-1:0]   deg_ra, earl_ra, lat_ra;
   logic [DEG_W-1:0]   deg_rd;
   logic [ET_W-1:0]    earl_rd;
   logic signed [LT_W-1:0] lat_rd;

   logic               issue, scan_done, tgt_in, src_in, hit;
   logic [VCNT_W-1:0]  eff_n;
   logic [ET_W-1:0]    relax_t;
   logic signed [LT_W-1:0] cand;
   logic signed [LS_W-1:0] ls_val;
   logic [DEG_W-1:0]   deg_dec;

   assign wr_edge.source   = req_edge_source;
   assign wr_edge.target   = req_edge_target;
   assign wr_edge.duration = req_edge_duration;
   assign ed               = edge_word_type'(ram_rdata);
   assign ram_we = (state_ff == S_IDLE) && start && (ecnt_ff < EDGE_LIMIT);

   cpa_edge_ram #(.DEPTH(MAX_EDGES), .WIDTH(EDGE_W)) u_edge_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ecnt_ff[EIDX_W-1:0]),
      .wr_data (EDGE_W'(wr_edge)),
      .rd_addr (addr_ff[EIDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   // Walk of the edge RAM: one read issued per cycle, data arriving in the next cycle.
   assign issue     = addr_ff < ecnt_ff;
   assign scan_done = !issue && !pv_ff;
   assign tgt_in    = {1'b0, ed.target} < n_ff;
   assign src_in    = {1'b0, ed.source} < n_ff;
   assign hit       = pv_ff && tgt_in && (ed.source == j_ff);

   assign eff_n = (cfg_ff == '0) ? VCNT_W'(1) :
                  (cfg_ff > VTX_LIMIT) ? VTX_LIMIT : cfg_ff;

   always_comb begin
      case (state_ff)
         S_PUSH:  deg_ra = vi_ff[VTX_W-1:0];
         default: deg_ra = ed.target;
      endcase
      case (state_ff)
         S_POP:   earl_ra = stack_ff[sp_ff[VTX_W-1:0] - VTX_W'(1)];
         S_LINIT: earl_ra = VTX_W'(n_ff - VCNT_W'(1));
         S_ESCAN: earl_ra = j_ff;
         default: earl_ra = ed.target;
      endcase
      case (state_ff)
         S_BHEAD: lat_ra = topo_ff[ord_ff[VTX_W-1:0] - VTX_W'(1)];
         default: lat_ra = ed.target;
      endcase
   end

   assign deg_rd  = indeg_ff[deg_ra];
   assign earl_rd = earl_ff[earl_ra];
   assign lat_rd  = lat_ff[lat_ra];
   assign deg_dec = deg_rd - DEG_W'(1);
   assign relax_t = ej_ff + ET_W'(ed.duration);
   assign cand    = lat_rd - $signed({{(LT_W-DUR_W){1'b0}}, ed.duration});
   assign ls_val  = LS_W'(lat_rd) - $signed({{(LS_W-DUR_W){1'b0}}, ed.duration});

   always_comb begin
      state_in = state_ff;
      cfg_in   = (csr_valid && csr_ready) ? csr_vertex_count : cfg_ff;
      ecnt_in  = ecnt_ff;
      n_in     = n_ff;
      addr_in  = addr_ff;
      pv_in    = 1'b0;
      sp_in    = sp_ff;
      ord_in   = ord_ff;
      vi_in    = vi_ff;
      act_in   = act_ff;
      emit_in  = emit_ff;
      j_in     = j_ff;
      ej_in    = ej_ff;
      acc_in   = acc_ff;
      rv_in    = 1'b0;
      rst_in   = 1'b0;
      rsrc_in  = rsrc_ff;
      rtgt_in  = rtgt_ff;
      rdur_in  = rdur_ff;
      res_in   = res_ff;
      rls_in   = rls_ff;
      rcrit_in = rcrit_ff;
      rlast_in = 1'b0;
      deg_we = 1'b0;  deg_wa = ed.target;  deg_wd = deg_rd;
      earl_we = 1'b0; earl_wa = ed.target; earl_wd = relax_t;
      lat_we = 1'b0;  lat_wa = j_ff;       lat_wd = acc_ff;
      stack_we = 1'b0; stack_wa = sp_ff[VTX_W-1:0]; stack_wd = ed.target;
      topo_we = 1'b0;  topo_wa = ord_ff[VTX_W-1:0]; topo_wd = j_ff;

      // Scan states share the read pointer.
      if (state_ff == S_DEG || state_ff == S_RELAX || state_ff == S_BSCAN ||
          state_ff == S_ESCAN) begin
         pv_in = issue;
         if (issue) begin
            addr_in = addr_ff + ECNT_W'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (ecnt_ff < EDGE_LIMIT) begin
                  ecnt_in = ecnt_ff + ECNT_W'(1);
               end
               if (req_last_edge) begin
                  n_in     = eff_n;
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            act_in = '0; sp_in = '0; ord_in = '0;
            addr_in = '0;
            state_in = S_DEG;
         end
         S_DEG: begin
            if (pv_ff && src_in && tgt_in) begin
               deg_we = 1'b1;
               deg_wd = deg_rd + DEG_W'(1);
               act_in = act_ff + ECNT_W'(1);
            end
            if (scan_done) begin
               vi_in = '0;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (vi_ff < n_ff) begin
               if (deg_rd == '0) begin
                  stack_we = 1'b1;
                  stack_wd = vi_ff[VTX_W-1:0];
                  sp_in = sp_ff + VCNT_W'(1);
               end
               vi_in = vi_ff + VCNT_W'(1);
            end else begin
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (sp_ff != '0) begin
               j_in    = earl_ra;
               ej_in   = earl_rd;
               topo_we = 1'b1;
               topo_wd = earl_ra;
               ord_in  = ord_ff + VCNT_W'(1);
               sp_in   = sp_ff - VCNT_W'(1);
               addr_in = '0;
               state_in = S_RELAX;
            end else if (ord_ff < n_ff) begin
               state_in = S_CYC;
            end else begin
               state_in = S_LINIT;
            end
         end
         S_RELAX: begin
            if (hit) begin
               deg_we = 1'b1;
               deg_wd = deg_dec;
               if (deg_dec == '0) begin
                  stack_we = 1'b1;
                  sp_in = sp_ff + VCNT_W'(1);
               end
               if (relax_t > earl_rd) begin
                  earl_we = 1'b1;
               end
            end
            if (scan_done) begin
               state_in = S_POP;
            end
         end
         S_LINIT: begin
            acc_in = $signed({1'b0, earl_rd});
            state_in = S_BHEAD;
         end
         S_BHEAD: begin
            if (ord_ff == '0) begin
               vi_in = '0;
               emit_in = '0;
               state_in = (act_ff == '0) ? S_DONE : S_EHEAD;
            end else begin
               j_in = lat_ra;
               acc_in = lat_rd;
               addr_in = '0;
               state_in = S_BSCAN;
            end
         end
         S_BSCAN: begin
            if (hit && (cand < acc_ff)) begin
               acc_in = cand;
            end
            if (scan_done) begin
               lat_we = 1'b1;
               ord_in = ord_ff - VCNT_W'(1);
               state_in = S_BHEAD;
            end
         end
         S_EHEAD: begin
            if (vi_ff < n_ff) begin
               j_in = vi_ff[VTX_W-1:0];
               addr_in = '0;
               state_in = S_ESCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ESCAN: begin
            if (hit) begin
               rv_in    = 1'b1;
               rsrc_in  = ed.source;
               rtgt_in  = ed.target;
               rdur_in  = ed.duration;
               res_in   = earl_rd;
               rls_in   = ls_val;
               rcrit_in = ($signed({2'b00, earl_rd}) == ls_val);
               rlast_in = (emit_ff + ECNT_W'(1)) == act_ff;
               emit_in  = emit_ff + ECNT_W'(1);
            end
            if (scan_done) begin
               vi_in = vi_ff + VCNT_W'(1);
               state_in = S_EHEAD;
            end
         end
         S_CYC: begin
            rv_in = 1'b1; rst_in = 1'b1; rlast_in = 1'b1;
            rsrc_in = '0; rtgt_in = '0; rdur_in = '0;
            res_in = '0; rls_in = '0; rcrit_in = 1'b0;
            state_in = S_DONE;
         end
         S_DONE: begin
            ecnt_in = '0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cfg_ff   <= VCNT_W'(1);
         ecnt_ff  <= '0;
         n_ff     <= VCNT_W'(1);
         pv_ff    <= 1'b0;
         sp_ff    <= '0;
         ord_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cfg_ff   <= cfg_in;
         ecnt_ff  <= ecnt_in;
         n_ff     <= n_in;
         pv_ff    <= pv_in;
         sp_ff    <= sp_in;
         ord_ff   <= ord_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      vi_ff    <= vi_in;
      act_ff   <= act_in;
      emit_ff  <= emit_in;
      j_ff     <= j_in;
      ej_ff    <= ej_in;
      acc_ff   <= acc_in;
      rst_ff   <= rst_in;
      rsrc_ff  <= rsrc_in;
      rtgt_ff  <= rtgt_in;
      rdur_ff  <= rdur_in;
      res_ff   <= res_in;
      rls_ff   <= rls_in;
      rcrit_ff <= rcrit_in;
      rlast_ff <= rlast_in;
      if (state_ff == S_INIT) begin
         for (int v = 0; v < MAX_VERTICES; v++) begin
            indeg_ff[v] <= '0;
            earl_ff[v]  <= '0;
         end
      end else begin
         if (deg_we) begin
            indeg_ff[deg_wa] <= deg_wd;
         end
         if (earl_we) begin
            earl_ff[earl_wa] <= earl_wd;
         end
      end
      if (state_ff == S_LINIT) begin
         for (int v = 0; v < MAX_VERTICES; v++) begin
            lat_ff[v] <= $signed({1'b0, earl_rd});
         end
      end else if (lat_we) begin
         lat_ff[lat_wa] <= lat_wd;
      end
      if (stack_we) begin
         stack_ff[stack_wa] <= stack_wd;
      end
      if (topo_we) begin
         topo_ff[topo_wa] <= topo_wd;
      end
   end

   assign busy               = state_ff != S_IDLE;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rv_ff;
   assign rsp_status         = rst_ff;
   assign rsp_out_source     = rsrc_ff;
   assign rsp_out_target     = rtgt_ff;
   assign rsp_out_duration   = rdur_ff;
   assign rsp_earliest_start = res_ff;
   assign rsp_latest_start   = rls_ff;
   assign rsp_is_critical    = rcrit_ff;
   assign rsp_last_result    = rlast_ff;

   // A result beat only follows the report or cycle-error states.
   `CPA_ASSERT_NOW(a_rsp_src, clock, reset, rv_ff,
      $past(state_ff) == S_ESCAN || $past(state_ff) == S_CYC, "stray result beat")
   // A cycle error is always the final beat of its run.
   `CPA_ASSERT_NOW(a_cyc_last, clock, reset, rv_ff && rst_ff, rlast_ff,
      "cycle error not marked last")
   // The ready stack never holds more than MAX_VERTICES entries.
   `CPA_ASSERT_NOW(a_sp_bound, clock, reset, 1'b1, sp_ff <= VTX_LIMIT,
      "ready stack overflow")
   // A non-final accepted edge with room in the store bumps the edge count.
   `CPA_ASSERT_NEXT(a_load, clock, reset,
      state_ff == S_IDLE && start && !req_last_edge && ecnt_ff < EDGE_LIMIT,
      ecnt_ff == $past(ecnt_ff) + ECNT_W'(1), "edge count did not advance")
endmodule
`default_nettype wire
